### design/ngh_pkg.sv
// Shared types and constants for the noise gate with hysteresis and hold.
package ngh_pkg;

	localparam int SAMPLE_BITS     = 24;
	localparam int COEFF_FRAC_BITS = 24;
	localparam int COEFF_BITS      = COEFF_FRAC_BITS + 1;
	localparam int HOLD_BITS       = 16;
	localparam int CFG_DATA_BITS   = 25;
	localparam int CFG_INDEX_BITS  = 3;

	// Shared multiplier: signed operands wide enough for every product.
	localparam int MUL_BITS  = 26;
	localparam int PROD_BITS = 2 * MUL_BITS;

	localparam logic [SAMPLE_BITS-1:0] UNITY = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

	localparam logic                       RST_ENABLE      = 1'b1;
	localparam logic [SAMPLE_BITS-1:0]     RST_OPEN_LEVEL  = SAMPLE_BITS'(83886);
	localparam logic [SAMPLE_BITS-1:0]     RST_CLOSE_LEVEL = SAMPLE_BITS'(41943);
	localparam logic [SAMPLE_BITS-1:0]     RST_FLOOR_GAIN  = SAMPLE_BITS'(839);
	localparam logic [COEFF_FRAC_BITS-1:0] RST_DECAY       = COEFF_FRAC_BITS'(16742271);
	localparam logic [COEFF_BITS-1:0]      RST_ATTACK      = COEFF_BITS'(345800);
	localparam logic [COEFF_BITS-1:0]      RST_RELEASE     = COEFF_BITS'(24127);
	localparam logic [HOLD_BITS-1:0]       RST_HOLD_LENGTH = HOLD_BITS'(2400);

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_ENABLE         = 3'd0,
		REG_OPEN_LEVEL     = 3'd1,
		REG_CLOSE_LEVEL    = 3'd2,
		REG_FLOOR_GAIN     = 3'd3,
		REG_DETECTOR_DECAY = 3'd4,
		REG_ATTACK_COEFF   = 3'd5,
		REG_RELEASE_COEFF  = 3'd6,
		REG_HOLD_LENGTH    = 3'd7
	} reg_index_t;

	typedef struct packed {
		logic                       enable;
		logic [SAMPLE_BITS-1:0]     open_level;
		logic [SAMPLE_BITS-1:0]     close_level;
		logic [SAMPLE_BITS-1:0]     floor_gain;
		logic [COEFF_FRAC_BITS-1:0] detector_decay;
		logic [COEFF_BITS-1:0]      attack_coeff;
		logic [COEFF_BITS-1:0]      release_coeff;
		logic [HOLD_BITS-1:0]       hold_length;
	} cfg_t;

	typedef struct packed {
		logic load_in;
		logic env_mul;
		logic gate_upd;
		logic step_mul;
		logic gain_upd;
		logic emit;
	} cmd_t;

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_ENV  = 6'b000010,
		ST_GATE = 6'b000100,
		ST_STEP = 6'b001000,
		ST_GAIN = 6'b010000,
		ST_EMIT = 6'b100000
	} state_t;

endpackage

### design/ngh_cfg_regs.sv
// Configuration register bank of the noise gate.
module ngh_cfg_regs (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 write_enable,
	input  logic [ngh_pkg::CFG_INDEX_BITS-1:0]   reg_index,
	input  logic [ngh_pkg::CFG_DATA_BITS-1:0]    write_data,
	output ngh_pkg::cfg_t                        cfg
);

	ngh_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enable         <= ngh_pkg::RST_ENABLE;
			cfg_q.open_level     <= ngh_pkg::RST_OPEN_LEVEL;
			cfg_q.close_level    <= ngh_pkg::RST_CLOSE_LEVEL;
			cfg_q.floor_gain     <= ngh_pkg::RST_FLOOR_GAIN;
			cfg_q.detector_decay <= ngh_pkg::RST_DECAY;
			cfg_q.attack_coeff   <= ngh_pkg::RST_ATTACK;
			cfg_q.release_coeff  <= ngh_pkg::RST_RELEASE;
			cfg_q.hold_length    <= ngh_pkg::RST_HOLD_LENGTH;
		end else if (write_enable) begin
			case (ngh_pkg::reg_index_t'(reg_index))
				ngh_pkg::REG_ENABLE: begin
					cfg_q.enable <= write_data[0];
				end
				ngh_pkg::REG_OPEN_LEVEL: begin
					cfg_q.open_level <= write_data[ngh_pkg::SAMPLE_BITS-1:0];
				end
				ngh_pkg::REG_CLOSE_LEVEL: begin
					cfg_q.close_level <= write_data[ngh_pkg::SAMPLE_BITS-1:0];
				end
				ngh_pkg::REG_FLOOR_GAIN: begin
					cfg_q.floor_gain <= write_data[ngh_pkg::SAMPLE_BITS-1:0];
				end
				ngh_pkg::REG_DETECTOR_DECAY: begin
					cfg_q.detector_decay <= write_data[ngh_pkg::COEFF_FRAC_BITS-1:0];
				end
				ngh_pkg::REG_ATTACK_COEFF: begin
					cfg_q.attack_coeff <= write_data[ngh_pkg::COEFF_BITS-1:0];
				end
				ngh_pkg::REG_RELEASE_COEFF: begin
					cfg_q.release_coeff <= write_data[ngh_pkg::COEFF_BITS-1:0];
				end
				ngh_pkg::REG_HOLD_LENGTH: begin
					cfg_q.hold_length <= write_data[ngh_pkg::HOLD_BITS-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### design/ngh_ctrl.sv
// Sequencing state machine of the noise gate.
module ngh_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	output logic          out_valid,
	input  logic          out_stall,
	input  logic          enable,
	output ngh_pkg::cmd_t cmd
);

	ngh_pkg::state_t state_q, state_d;
	logic            out_valid_q;
	logic            accept;
	logic            out_free;

	assign in_stall = (state_q != ngh_pkg::ST_IDLE);
	assign accept   = in_valid && !in_stall;
	// The output register can take a new word when empty or being drained.
	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ngh_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = enable ? ngh_pkg::ST_ENV : ngh_pkg::ST_EMIT;
				end
			end
			ngh_pkg::ST_ENV:  state_d = ngh_pkg::ST_GATE;
			ngh_pkg::ST_GATE: state_d = ngh_pkg::ST_STEP;
			ngh_pkg::ST_STEP: state_d = ngh_pkg::ST_GAIN;
			ngh_pkg::ST_GAIN: state_d = ngh_pkg::ST_EMIT;
			ngh_pkg::ST_EMIT: begin
				if (out_free) begin
					state_d = ngh_pkg::ST_IDLE;
				end
			end
			default: state_d = ngh_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd          = '0;
		cmd.load_in  = accept;
		cmd.env_mul  = (state_q == ngh_pkg::ST_ENV);
		cmd.gate_upd = (state_q == ngh_pkg::ST_GATE);
		cmd.step_mul = (state_q == ngh_pkg::ST_STEP);
		cmd.gain_upd = (state_q == ngh_pkg::ST_GAIN);
		cmd.emit     = (state_q == ngh_pkg::ST_EMIT) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ngh_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

### design/ngh_dp.sv
// Datapath of the noise gate: envelope, gate flag, gain and shared multiplier.
module ngh_dp (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  ngh_pkg::cfg_t                           cfg,
	input  ngh_pkg::cmd_t                           cmd,
	input  logic signed [ngh_pkg::SAMPLE_BITS-1:0]  sample_in,
	input  logic                                    block_end_in,
	output logic signed [ngh_pkg::SAMPLE_BITS-1:0]  sample_out,
	output logic                                    block_end_out
);

	localparam int SB  = ngh_pkg::SAMPLE_BITS;
	localparam int CF  = ngh_pkg::COEFF_FRAC_BITS;
	localparam int CB  = ngh_pkg::COEFF_BITS;
	localparam int MB  = ngh_pkg::MUL_BITS;
	localparam int PB  = ngh_pkg::PROD_BITS;
	localparam int GB  = MB + 2;

	logic signed [SB-1:0]        x_q;
	logic                        mark_q;
	logic [SB-1:0]               ax_q;
	logic [SB-1:0]               env_q;
	logic [ngh_pkg::HOLD_BITS-1:0] hold_q;
	logic                        open_q;
	logic [SB-1:0]               gain_q;
	logic                        rise_q;
	logic [PB-1:0]               prod_q;
	logic signed [SB-1:0]        sample_out_q;
	logic                        block_end_q;

	logic [SB-1:0]               ax_c;
	logic [SB-1:0]               env_c;
	logic [SB-1:0]               target_c;
	logic                        rise_c;
	logic [SB-1:0]               diff_c;
	logic [CB-1:0]               coeff_c;
	logic signed [MB-1:0]        mul_a;
	logic signed [MB-1:0]        mul_b;
	logic signed [PB-1:0]        product;
	logic [MB-1:0]               step_c;
	logic signed [GB-1:0]        g_c;

	// Magnitude; the most negative sample maps to unity as an unsigned value.
	assign ax_c = x_q[SB-1] ? SB'(~x_q + 1'b1) : x_q;

	assign target_c = open_q ? ngh_pkg::UNITY : cfg.floor_gain;
	assign rise_c   = (target_c > gain_q);
	assign diff_c   = rise_c ? (target_c - gain_q) : (gain_q - target_c);
	assign coeff_c  = rise_c ? cfg.attack_coeff : cfg.release_coeff;

	always_comb begin
		if (cmd.env_mul) begin
			mul_a = $signed({{(MB-SB){1'b0}}, env_q});
			mul_b = $signed({{(MB-CF){1'b0}}, cfg.detector_decay});
		end else if (cmd.step_mul) begin
			mul_a = $signed({{(MB-SB){1'b0}}, diff_c});
			mul_b = $signed({{(MB-CB){1'b0}}, coeff_c});
		end else begin
			mul_a = $signed({{(MB-SB){x_q[SB-1]}}, x_q});
			mul_b = $signed({{(MB-SB){1'b0}}, gain_q});
		end
	end

	assign product = mul_a * mul_b;

	assign env_c  = (ax_q > env_q) ? ax_q : prod_q[SB+CF-1:CF];
	assign step_c = prod_q[MB+CF-1:CF];

	always_comb begin
		if (rise_q) begin
			g_c = $signed({{(GB-SB){1'b0}}, gain_q}) + $signed({2'b00, step_c});
		end else begin
			g_c = $signed({{(GB-SB){1'b0}}, gain_q}) - $signed({2'b00, step_c});
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			x_q    <= sample_in;
			mark_q <= block_end_in;
		end
		if (cmd.env_mul) begin
			ax_q <= ax_c;
		end
		if (cmd.env_mul || cmd.step_mul) begin
			prod_q <= PB'(product);
		end
		if (cmd.step_mul) begin
			rise_q <= rise_c;
		end
		if (cmd.emit) begin
			sample_out_q <= cfg.enable ? product[SB+SB-2:SB-1] : x_q;
			block_end_q  <= mark_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			env_q  <= '0;
			hold_q <= '0;
			open_q <= 1'b0;
			gain_q <= ngh_pkg::RST_FLOOR_GAIN;
		end else begin
			if (cmd.gate_upd) begin
				env_q <= env_c;
				if (env_c > cfg.open_level) begin
					open_q <= 1'b1;
					hold_q <= cfg.hold_length;
				end else if (env_c < cfg.close_level) begin
					if (hold_q != '0) begin
						hold_q <= hold_q - 1'b1;
					end else begin
						open_q <= 1'b0;
					end
				end
			end
			if (cmd.gain_upd) begin
				if (g_c > $signed({{(GB-SB){1'b0}}, ngh_pkg::UNITY})) begin
					gain_q <= ngh_pkg::UNITY;
				end else if (g_c < $signed({{(GB-SB){1'b0}}, cfg.floor_gain})) begin
					gain_q <= cfg.floor_gain;
				end else begin
					gain_q <= g_c[SB-1:0];
				end
			end
		end
	end

	assign sample_out    = sample_out_q;
	assign block_end_out = block_end_q;

endmodule

### design/noise_gate_hysteresis_hold_core.sv
// Top level of the noise gate with peak detector, hysteresis and hold.
//
// Usage: each input word carries one signed Q1.23 sample and a block end
// mark; each accepted word yields exactly one output word with the gated
// sample and the copied mark. Both channels use valid and stall: a word
// moves on a rising edge where valid is high and stall is low.
// Configuration is written through write_enable, reg_index and write_data
// while the block is idle; registers take effect on the next word.
// With the gate enabled, each accepted word passes through the envelope,
// gate, smoothing step, gain update and emit states in turn; with the
// gate disabled it goes straight to the emit state. A new word is taken
// only once the last one has been emitted and the block is idle again.
// The sequence is set by one shared 26 by 26 bit multiplier, used in turn
// for the envelope decay, the gain smoothing step and the output product.
// Reset puts the registers at their default values, clears the envelope,
// hold count and gate flag, and sets the gain to the default floor gain.
// When the receiver stalls, the finished word stays in the output register
// and the block holds its last step until that register can be reloaded,
// stalling its input meanwhile.
module noise_gate_hysteresis_hold_core (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic signed [ngh_pkg::SAMPLE_BITS-1:0] sample_in,
	input  logic                                   block_end_in,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic signed [ngh_pkg::SAMPLE_BITS-1:0] sample_out,
	output logic                                   block_end_out,
	input  logic                                   write_enable,
	input  logic [ngh_pkg::CFG_INDEX_BITS-1:0]     reg_index,
	input  logic [ngh_pkg::CFG_DATA_BITS-1:0]      write_data
);

	ngh_pkg::cfg_t cfg;
	ngh_pkg::cmd_t cmd;

	// Register bank: the user must write it only between words; unchecked.
	ngh_cfg_regs u_cfg (
		.clk          (clk),
		.arst_n       (arst_n),
		.write_enable (write_enable),
		.reg_index    (reg_index),
		.write_data   (write_data),
		.cfg          (cfg)
	);

	// The controller steps each word through envelope, gate, smoothing step,
	// gain update, output (only output if disabled), and owns both handshakes.
	ngh_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.enable    (cfg.enable),
		.cmd       (cmd)
	);

	// The datapath holds the gate state and the output payload register.
	ngh_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.cmd           (cmd),
		.sample_in     (sample_in),
		.block_end_in  (block_end_in),
		.sample_out    (sample_out),
		.block_end_out (block_end_out)
	);

endmodule
